>>> rtl/core/mlbt_pkg.sv
package mlbt_pkg;

  // Table geometry.
  localparam int unsigned TableDepth = 512;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned MacW       = 48;
  localparam int unsigned EntryW     = MacW + 1;

  // Forwarding decision codes.
  typedef enum logic [1:0] {
    ACT_FILTER  = 2'd0,
    ACT_FORWARD = 2'd1,
    ACT_FLOOD   = 2'd2
  } action_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic read;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic last_read;
  } status_t;

endpackage

>>> rtl/core/mac_learning_bridge_table.sv
// Channel   Handshake            Ports
// -------   ------------------   ---------------------------------------------
// input     start_i & !busy_o    dest_mac_i, source_mac_i, arrival_port_i
// result    done_o, one cycle    action_o, out_port_o, learned_new_o,
//                                table_full_o
//
// The linear scan of the entry memory, one read port entry per cycle, sets how
// long an item takes from accept to the next accept; while the table is empty
// the scan is skipped.
// The result strobe comes in the first idle cycle, when the next item may
// already be accepted. Reset clears count, scan state and strobe; no clearing pass.
// The receiver cannot stall: each result shows for exactly one cycle.
module mac_learning_bridge_table (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [mlbt_pkg::MacW-1:0] dest_mac_i,
  input  logic [mlbt_pkg::MacW-1:0] source_mac_i,
  input  logic                      arrival_port_i,
  output logic                      done_o,
  output logic [1:0]                action_o,
  output logic                      out_port_o,
  output logic                      learned_new_o,
  output logic                      table_full_o
);

  mlbt_pkg::cmd_t    cmd;
  mlbt_pkg::status_t status;

  // Sequencer for the learn-and-lookup pass.
  mlbt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // Entry memory, comparators and result registers.
  mlbt_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .dest_mac_i     (dest_mac_i),
    .source_mac_i   (source_mac_i),
    .arrival_port_i (arrival_port_i),
    .done_o         (done_o),
    .action_o       (action_o),
    .out_port_o     (out_port_o),
    .learned_new_o  (learned_new_o),
    .table_full_o   (table_full_o)
  );

endmodule

>>> rtl/core/mlbt_ctrl.sv
module mlbt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  mlbt_pkg::status_t status_i,
  output mlbt_pkg::cmd_t    cmd_o,
  output logic             busy_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_WAIT   = 4'b0100,
    S_COMMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next-state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.count_zero ? S_COMMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.read = 1'b1;
        if (status_i.last_read) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        // The last entry read is compared in this cycle.
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> rtl/core/mlbt_datapath.sv
module mlbt_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mlbt_pkg::cmd_t               cmd_i,
  output mlbt_pkg::status_t            status_o,
  input  logic [mlbt_pkg::MacW-1:0]    dest_mac_i,
  input  logic [mlbt_pkg::MacW-1:0]    source_mac_i,
  input  logic                         arrival_port_i,
  output logic                         done_o,
  output logic [1:0]                   action_o,
  output logic                         out_port_o,
  output logic                         learned_new_o,
  output logic                         table_full_o
);

  // Entry memory: MAC address in the upper bits, port in bit zero.
  logic [mlbt_pkg::EntryW-1:0] entry_mem_q [mlbt_pkg::TableDepth];
  logic [mlbt_pkg::EntryW-1:0] rd_data_q;

  // Latched header of the item in work.
  logic [mlbt_pkg::MacW-1:0] dst_q;
  logic [mlbt_pkg::MacW-1:0] src_q;
  logic                      port_q;

  // Scan state and match flags.
  logic [mlbt_pkg::IdxW-1:0] rd_idx_q;
  logic [mlbt_pkg::IdxW-1:0] cmp_idx_q;
  logic                      cmp_vld_q;
  logic                      src_hit_q;
  logic [mlbt_pkg::IdxW-1:0] src_idx_q;
  logic                      dst_hit_q;
  logic                      dst_port_q;
  logic [mlbt_pkg::CntW-1:0] count_q;

  // Result registers.
  logic                      done_q;
  mlbt_pkg::action_e         action_q;
  logic                      out_port_q;
  logic                      learned_q;
  logic                      full_q;

  // Compare of the entry read in the previous cycle.
  logic                      src_match;
  logic                      dst_match;
  logic [mlbt_pkg::MacW-1:0] rd_mac;
  logic                      rd_port;

  assign rd_mac    = rd_data_q[mlbt_pkg::EntryW-1:1];
  assign rd_port   = rd_data_q[0];
  assign src_match = cmp_vld_q && (rd_mac == src_q);
  assign dst_match = cmp_vld_q && (rd_mac == dst_q);

  // Commit-time decision.
  logic                      can_learn;
  logic                      learned;
  logic                      full;
  logic                      same_mac;
  logic                      wr_en;
  logic [mlbt_pkg::IdxW-1:0] wr_addr;
  mlbt_pkg::action_e         action_d;
  logic                      out_port_d;

  always_comb begin
    can_learn = (count_q != mlbt_pkg::CntW'(mlbt_pkg::TableDepth));
    learned   = !src_hit_q && can_learn;
    full      = !src_hit_q && !can_learn;
    same_mac  = (dst_q == src_q);
    wr_en     = cmd_i.commit && (src_hit_q || can_learn);
    wr_addr   = src_hit_q ? src_idx_q : count_q[mlbt_pkg::IdxW-1:0];
    if (same_mac && (src_hit_q || learned)) begin
      // The source was just placed on the arrival port.
      action_d   = mlbt_pkg::ACT_FILTER;
      out_port_d = 1'b0;
    end else if (dst_hit_q && (dst_port_q == port_q)) begin
      action_d   = mlbt_pkg::ACT_FILTER;
      out_port_d = 1'b0;
    end else if (dst_hit_q) begin
      action_d   = mlbt_pkg::ACT_FORWARD;
      out_port_d = dst_port_q;
    end else begin
      action_d   = mlbt_pkg::ACT_FLOOD;
      out_port_d = !port_q;
    end
  end

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem_q[wr_addr] <= {src_q, port_q};
    end
    rd_data_q <= entry_mem_q[rd_idx_q];
  end

  // Header latch and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dst_q  <= dest_mac_i;
      src_q  <= source_mac_i;
      port_q <= arrival_port_i;
    end
    if (cmd_i.commit) begin
      action_q   <= action_d;
      out_port_q <= out_port_d;
      learned_q  <= learned;
      full_q     <= full;
    end
    cmp_idx_q <= rd_idx_q;
  end

  // Scan control, match flags, entry count and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q   <= '0;
      cmp_vld_q  <= 1'b0;
      src_hit_q  <= 1'b0;
      src_idx_q  <= '0;
      dst_hit_q  <= 1'b0;
      dst_port_q <= 1'b0;
      count_q    <= '0;
      done_q     <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.read;
      done_q    <= cmd_i.commit;
      if (cmd_i.load) begin
        rd_idx_q  <= '0;
        src_hit_q <= 1'b0;
        dst_hit_q <= 1'b0;
      end else begin
        if (cmd_i.read) begin
          rd_idx_q <= rd_idx_q + mlbt_pkg::IdxW'(1);
        end
        // Stored addresses are unique, so at most one entry matches each.
        if (src_match) begin
          src_hit_q <= 1'b1;
          src_idx_q <= cmp_idx_q;
        end
        if (dst_match) begin
          dst_hit_q  <= 1'b1;
          dst_port_q <= rd_port;
        end
      end
      if (cmd_i.commit && learned) begin
        count_q <= count_q + mlbt_pkg::CntW'(1);
      end
    end
  end

  assign status_o.count_zero = (count_q == '0);
  assign status_o.last_read  =
    ((mlbt_pkg::CntW'(rd_idx_q) + mlbt_pkg::CntW'(1)) == count_q);

  assign done_o        = done_q;
  assign action_o      = action_q;
  assign out_port_o    = out_port_q;
  assign learned_new_o = learned_q;
  assign table_full_o  = full_q;

endmodule
